// ===== rtl/mchp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater PWM package
// Command codes, channel record type and fixed constants of the heater driver.
// ----------------------------------------------------------------------------
package mchp_pkg;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ALL_OFF = 3'd1;
    localparam logic [2:0] CMD_ALL_ON  = 3'd2;
    localparam logic [2:0] CMD_OFF     = 3'd3;
    localparam logic [2:0] CMD_ON      = 3'd4;
    localparam logic [2:0] CMD_ON_DUR  = 3'd5;
    localparam logic [2:0] CMD_SET_PWM = 3'd6;
    localparam logic [2:0] CMD_STEP    = 3'd7;

    localparam logic [6:0]  FULL_DUTY   = 7'd100;
    localparam logic [31:0] RUN_FOREVER = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [6:0]  duty;
        logic [31:0] run_length;
        logic [31:0] run_start;
        logic [31:0] phase_start;
    } t_chan_rec;

endpackage

// ===== rtl/multi_channel_heater_pwm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel heater PWM unit
// Slow PWM heater driver with a run timeout per channel; channel records
// live in one synchronous memory that a sequencer reads, updates and rewrites.
// ----------------------------------------------------------------------------
// Sequence: a command walks the channels in use; each channel record is read,
// updated and written back, with a modulo step before the write for a tick on a
// driven channel, plus a second restagger pass when a set command, a step or an
// expiring run flags a duty change. Throughput: one request at a time.
// Reset: synchronous, active low; clears the clock, drive bits, channel
// count and the per-entry valid bits, so every channel record reads as zero.
module multi_channel_heater_pwm_unit
    import mchp_pkg::*;
#(
    parameter int CHANNELS         = 4,
    parameter int PERIOD_MS        = 1000,
    parameter int RELAX_TIMEOUT_MS = 60000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [3:0]         i_channel,
    input  logic [6:0]         i_duty_percent,
    input  logic signed [31:0] i_duration_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_heater_on,
    output logic               o_accepted,
    output logic [6:0]         o_channel_percent
);

    localparam int CNW = $clog2(CHANNELS + 1);
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW  = $clog2(PERIOD_MS + 1);
    localparam int AW  = PW + 1;
    localparam logic [PW-1:0] PERIOD = PW'(PERIOD_MS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_RRD  = 3'd5;
    localparam logic [2:0] S_RWR  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    function automatic int on_time_of(input int d);
        return (d * PERIOD_MS) / 100;
    endfunction

    logic [PW-1:0] w_on_tab [128];
    for (genvar g = 0; g < 128; g++) begin : g_tab
        assign w_on_tab[g] = PW'(on_time_of(g));
    end

    t_chan_rec       mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    t_chan_rec       r_rdata;
    logic            r_rvld;
    t_chan_rec       w_rec;

    logic [2:0]      r_state;
    logic [2:0]      r_cnt;
    logic [31:0]     r_now;
    logic [3:0]      r_bits;
    logic [2:0]      r_cmd;
    logic [3:0]      r_ch;
    logic [6:0]      r_pct;
    logic [31:0]     r_dur;
    logic            r_ok;
    logic            r_vch;
    logic [6:0]      r_pct_out;
    logic [CNW-1:0]  r_idx;
    logic [AW-1:0]   r_acc;
    logic            r_flag;
    t_chan_rec       r_wrec;
    logic [31:0]     r_dx;
    logic [PW-1:0]   r_rem;
    logic [2:0]      r_dcnt;
    logic            r_out_valid;
    logic [3:0]      r_out_bits;
    logic            r_out_acc;
    logic [6:0]      r_out_pct;

    logic [CNW-1:0]  w_n;
    logic            w_in_vch;
    logic            w_in_ok;
    logic            w_last;
    logic [31:0]     w_base;
    logic            w_sel;
    logic            w_exp;
    logic            w_kill;
    t_chan_rec       n_wrec;
    logic            n_flag;
    logic [AW-1:0]   n_acc;
    logic [AW-1:0]   n_racc;
    logic [PW-1:0]   n_rem;
    logic [PW:0]     w_t;
    logic            w_wr_en;
    t_chan_rec       w_wr_data;

    assign w_n = (32'(r_cnt) > CHANNELS) ? CNW'(CHANNELS) : CNW'(r_cnt);
    assign w_in_vch = 32'(i_channel) < 32'(w_n);
    assign w_in_ok = (i_command == CMD_TICK) || (i_command == CMD_ALL_OFF)
        || (i_command == CMD_ALL_ON) || (i_command == CMD_STEP)
        || (w_in_vch && !((i_command == CMD_SET_PWM) && (i_duty_percent > FULL_DUTY)));
    assign w_last = !(32'(r_idx) + 32'd1 < 32'(w_n));
    assign w_base = r_now - 32'(PERIOD_MS);
    assign w_rec = r_rvld ? r_rdata : '0;
    assign w_sel = 32'(r_idx) == 32'(r_ch);
    assign w_exp = (r_now - w_rec.run_start) > w_rec.run_length;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_heater_on = r_out_bits;
    assign o_accepted = r_out_acc;
    assign o_channel_percent = r_out_pct;

    always_comb begin
        n_wrec = w_rec;
        n_flag = r_flag;
        w_kill = 1'b0;
        if (r_ok) begin
            unique case (r_cmd)
                CMD_TICK: begin
                    w_kill = w_exp && (w_rec.duty != 7'd0);
                    if (w_kill) begin
                        n_wrec.duty = 7'd0;
                    end
                    n_flag = r_flag || w_kill;
                    n_wrec.phase_start = n_flag ? (w_base + 32'(r_acc)) : w_rec.phase_start;
                end
                CMD_ALL_OFF, CMD_ALL_ON: begin
                    n_wrec.duty = (r_cmd == CMD_ALL_ON) ? FULL_DUTY : 7'd0;
                    n_wrec.run_length = (r_cmd == CMD_ALL_ON) ? RUN_FOREVER : 32'd0;
                    n_flag = 1'b1;
                end
                CMD_OFF, CMD_ON: begin
                    if (w_sel) begin
                        n_wrec.duty = (r_cmd == CMD_ON) ? FULL_DUTY : 7'd0;
                        n_wrec.run_length = (r_cmd == CMD_ON) ? RUN_FOREVER : 32'd0;
                    end
                    n_flag = 1'b1;
                end
                CMD_ON_DUR, CMD_SET_PWM: begin
                    if (w_sel) begin
                        n_wrec.duty = (r_cmd == CMD_ON_DUR) ? FULL_DUTY : r_pct;
                        n_wrec.run_length = r_dur[31] ? RUN_FOREVER : r_dur;
                        n_wrec.run_start = r_now;
                    end
                    n_flag = 1'b1;
                end
                CMD_STEP: begin
                    if (w_rec.duty != 7'd0) begin
                        n_wrec.duty = w_rec.duty - 7'd1;
                        n_wrec.run_length = (w_rec.run_length != RUN_FOREVER)
                            ? 32'(RELAX_TIMEOUT_MS) : RUN_FOREVER;
                        n_flag = 1'b1;
                    end
                end
                default: begin
                    n_flag = r_flag;
                end
            endcase
        end
    end

    always_comb begin
        n_acc = r_acc + AW'(w_on_tab[n_wrec.duty]);
        if (n_acc > AW'(PERIOD)) begin
            n_acc = n_acc - AW'(PERIOD);
        end
        n_racc = r_acc + AW'(w_on_tab[w_rec.duty]);
        if (n_racc > AW'(PERIOD)) begin
            n_racc = n_racc - AW'(PERIOD);
        end
    end

    always_comb begin
        n_rem = r_rem;
        w_t = '0;
        for (int k = 0; k < 4; k++) begin
            w_t = {n_rem, r_dx[31 - k]};
            if (w_t >= {1'b0, PERIOD}) begin
                w_t = w_t - {1'b0, PERIOD};
            end
            n_rem = w_t[PW-1:0];
        end
    end

    always_comb begin
        w_wr_en = 1'b0;
        w_wr_data = r_wrec;
        if (r_state == S_WR) begin
            w_wr_en = 1'b1;
        end else if (r_state == S_RWR) begin
            w_wr_en = 1'b1;
            w_wr_data = w_rec;
            w_wr_data.phase_start = w_base + 32'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_idx[CIW-1:0]];
        r_rvld <= r_vld[r_idx[CIW-1:0]];
        if (w_wr_en) begin
            mem[r_idx[CIW-1:0]] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= 3'd0;
            r_now <= 32'd0;
            r_bits <= 4'd0;
            r_vld <= '0;
            r_out_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cnt <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_vld[r_idx[CIW-1:0]] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_command;
                        r_ch <= i_channel;
                        r_pct <= i_duty_percent;
                        r_dur <= i_duration_ms;
                        r_ok <= w_in_ok;
                        r_vch <= w_in_vch;
                        r_pct_out <= 7'd0;
                        r_idx <= '0;
                        r_acc <= '0;
                        r_flag <= 1'b0;
                        if (i_command == CMD_TICK) begin
                            r_now <= r_now + 32'd1;
                            r_bits <= 4'd0;
                        end
                        r_state <= (w_n == '0) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_wrec <= n_wrec;
                    r_flag <= n_flag;
                    r_acc <= n_acc;
                    if (w_sel) begin
                        r_pct_out <= n_wrec.duty;
                    end
                    r_dx <= r_now - n_wrec.phase_start;
                    r_rem <= '0;
                    r_dcnt <= 3'd0;
                    r_state <= (r_ok && (r_cmd == CMD_TICK) && (n_wrec.duty != 7'd0))
                        ? S_DIV : S_WR;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dx <= {r_dx[27:0], 4'd0};
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'd7) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_ok && (r_cmd == CMD_TICK) && (r_wrec.duty != 7'd0)
                        && (r_rem <= w_on_tab[r_wrec.duty])) begin
                        r_bits <= r_bits | 4'(32'd1 << r_idx);
                    end
                    if (w_last) begin
                        r_idx <= '0;
                        r_acc <= '0;
                        r_state <= r_flag ? S_RRD : S_DONE;
                    end else begin
                        r_idx <= r_idx + CNW'(1);
                        r_state <= S_RD;
                    end
                end
                S_RRD: begin
                    r_state <= S_RWR;
                end
                S_RWR: begin
                    r_acc <= n_racc;
                    if (w_last) begin
                        r_idx <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + CNW'(1);
                        r_state <= S_RRD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bits <= r_bits;
                        r_out_acc <= r_ok;
                        r_out_pct <= r_vch ? r_pct_out : 7'd0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mchp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater PWM port checker
// Watches the request and result channels of the heater PWM unit.
// ----------------------------------------------------------------------------
module mchp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_channel_percent
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_channel_percent))
        else $error("result dropped before it was taken");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_channel_percent <= 7'd100)
        else $error("reported duty above full");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while the first is in work");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid))
        else $error("unit went busy without a request");

endmodule

bind multi_channel_heater_pwm_unit mchp_checker u_mchp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_channel_percent(o_channel_percent)
);
